// ----- src/ecbt_pkg.sv -----
// Shared constants and types for the event counter bank.
package ecbt_pkg;

  // Bank size and derived address width
  localparam int NUM_COUNTERS = 32;
  localparam int ADDR_W       = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;
  localparam int IDX_W        = 8;
  localparam logic [IDX_W:0] NUM_LIMIT = (IDX_W + 1)'(NUM_COUNTERS);

  // Field widths
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 31;
  localparam int FRAME_W = 31;
  localparam int OUT_W   = 128;

  localparam logic [CNT_W-1:0]   CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  // Item kinds; the unused code behaves as a query
  localparam logic [KIND_W-1:0] KIND_REPORT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

  // One bank entry as stored in the RAM
  typedef struct packed {
    logic [CNT_W-1:0]   count;
    logic [FRAME_W-1:0] first;
    logic [FRAME_W-1:0] last;
  } ecbt_entry_t;

  localparam int ENTRY_W = $bits(ecbt_entry_t);

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // take the request and start the entry read
    logic exec;   // update the entry and load the result register
  } ecbt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic slot_free;  // result register empty or being drained
  } ecbt_stat_t;

endpackage

// ----- src/event_counter_bank_with_timestamps.sv -----
// Top level of the saturating event counter bank with first/last frame capture.
//
//  channel | direction | tdata                    | tuser
//  s_*     | in        | [7:0] counter_index      | [1:0] kind
//  m_*     | out       | index_valid, event_count, | none
//          |           | first_frame, last_frame,  |
//          |           | current_frame             |
//
// For each request, the accept cycle starts the registered RAM read; the
// update step that follows does the read-modify-write of the entry and loads
// the result register. s_tready is low while a request is in progress.
// A result waiting in the output register delays only the update cycle of the
// following request. Reset clears the per-entry valid bits and the frame clock
// at once; there is no clearing pass.
module event_counter_bank_with_timestamps
  import ecbt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IDX_W-1:0]   s_tdata,   // [7:0] counter_index
  input  logic [KIND_W-1:0]  s_tuser,   // [1:0] kind
  output logic               m_tvalid,
  input  logic               m_tready,
  // [0] index_valid, [31:1] event_count, [63:32] first_frame,
  // [95:64] last_frame, [126:96] current_frame, [127] zero
  output logic [OUT_W-1:0]   m_tdata
);

  ecbt_cmd_t  cmd;
  ecbt_stat_t stat;

  ecbt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ecbt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_index (s_tdata),
    .in_kind  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // One request at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while another is in progress");

  // An update always produces a result
  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> m_tvalid)
    else $error("update did not load the result register");

  // Out-of-range index reads back as empty
  a_invalid_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> (m_tdata[31:1] == '0) && (m_tdata[95:32] == '1))
    else $error("invalid index returned counter contents");

  // A counter that fired has non-negative first and last frames
  a_fired_first: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[31:1] != '0)) |-> (!m_tdata[63] && !m_tdata[95]))
    else $error("fired counter returned a negative frame");

endmodule

// ----- src/ecbt_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ecbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/ecbt_ctrl.sv -----
// Controller for the event counter bank: request intake and update sequencing.
module ecbt_ctrl
  import ecbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  ecbt_stat_t stat,
  output ecbt_cmd_t  cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state;
  logic   in_rdy;

  // Commands
  always_comb begin
    cmd.load = s_tvalid && in_rdy;
    cmd.exec = (state == ST_EXEC) && stat.slot_free;
  end

  assign s_tready = in_rdy;

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      in_rdy <= 1'b1;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.load) begin
            state  <= ST_EXEC;
            in_rdy <= 1'b0;
          end
        end
        ST_EXEC: begin
          // wait here while the previous result is still unclaimed
          if (cmd.exec) begin
            state  <= ST_IDLE;
            in_rdy <= 1'b1;
          end
        end
        default: begin
          state  <= ST_IDLE;
          in_rdy <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ----- src/ecbt_dp.sv -----
// Datapath for the event counter bank: entry RAM, valid bits, frame clock, result register.
module ecbt_dp
  import ecbt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ecbt_cmd_t           cmd,
  output ecbt_stat_t          stat,
  input  logic [IDX_W-1:0]    in_index,
  input  logic [KIND_W-1:0]   in_kind,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_W-1:0]    m_tdata
);

  logic [KIND_W-1:0]     kind_q;
  logic [IDX_W-1:0]      idx_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [NUM_COUNTERS-1:0] vbits;
  logic [FRAME_W-1:0]    frame_clock;
  logic [FRAME_W-1:0]    frame_clock_next;
  logic [ENTRY_W-1:0]    rdata;
  ecbt_entry_t           cur;
  ecbt_entry_t           upd;
  ecbt_entry_t           after;
  logic                  idx_ok;
  logic                  hit;
  logic                  do_report;
  logic [31:0]           first_o;
  logic [31:0]           last_o;

  assign addr_q = idx_q[ADDR_W-1:0];

  // Entry store; read starts when the request is taken
  ecbt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_COUNTERS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.exec && do_report),
    .waddr (addr_q),
    .wdata (upd),
    .re    (cmd.load),
    .raddr (in_index[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= in_kind;
      idx_q  <= in_index;
    end
  end

  // Current entry; a never-written entry reads as zero
  always_comb begin
    idx_ok    = {1'b0, idx_q} < NUM_LIMIT;
    hit       = idx_ok && vbits[addr_q];
    cur       = hit ? ecbt_entry_t'(rdata) : '0;
    do_report = (kind_q == KIND_REPORT) && idx_ok;
  end

  // Report update: first frame on first event, saturating count
  always_comb begin
    upd.count = (cur.count == CNT_MAX) ? cur.count : cur.count + 1'b1;
    upd.first = (cur.count == '0) ? frame_clock : cur.first;
    upd.last  = frame_clock;
    after     = do_report ? upd : cur;
  end

  // Saturating frame tick
  always_comb begin
    frame_clock_next = frame_clock;
    if ((kind_q == KIND_TICK) && (frame_clock != FRAME_MAX)) begin
      frame_clock_next = frame_clock + 1'b1;
    end
  end

  // Frames read back as all ones when the counter never fired
  always_comb begin
    if (after.count != '0) begin
      first_o = {1'b0, after.first};
      last_o  = {1'b0, after.last};
    end else begin
      first_o = '1;
      last_o  = '1;
    end
  end

  assign stat.slot_free = !m_tvalid || m_tready;

  // Valid bits, frame clock and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      vbits       <= '0;
      frame_clock <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cmd.exec) begin
        frame_clock <= frame_clock_next;
        m_tvalid    <= 1'b1;
        if (do_report) begin
          vbits[addr_q] <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      m_tdata <= {1'b0, frame_clock_next, last_o, first_o, after.count, idx_ok};
    end
  end

endmodule

// ----- tb/event_counter_bank_with_timestamps_tb.sv -----
// Self-checking testbench for the event counter bank with first/last frame capture.
module event_counter_bank_with_timestamps_tb;
  import ecbt_pkg::*;

  // Unused kind code; the bank treats it as a query
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [31:0]       NO_FRAME   = 32'hffff_ffff;
  localparam int                RAND_ITEMS = 700;
  localparam int                PHASE_LEN  = 100;

  // One predicted result, plus the request that caused it for messages
  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   idx;
    logic               index_valid;
    logic [CNT_W-1:0]   event_count;
    logic [31:0]        first_frame;
    logic [31:0]        last_frame;
    logic [FRAME_W-1:0] current_frame;
  } bank_result_t;

  // Bank state mirror, result queue and mismatch count
  class counter_bank_scoreboard;
    logic [CNT_W-1:0]   hit_count  [NUM_COUNTERS];
    logic [FRAME_W-1:0] first_seen [NUM_COUNTERS];
    logic [FRAME_W-1:0] last_seen  [NUM_COUNTERS];
    logic [FRAME_W-1:0] frame_now;
    bank_result_t       pending_results[$];
    int                 errors;

    function new();
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        hit_count[i]  = '0;
        first_seen[i] = '0;
        last_seen[i]  = '0;
      end
      frame_now = '0;
      errors    = 0;
    endfunction

    function void report(string msg);
      errors++;
      $display("ERROR @%0t: %s", $time, msg);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Apply an accepted request to the mirror and queue its result
    function void note_request(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] idx);
      bank_result_t      r;
      bit                hit;
      logic [ADDR_W-1:0] a;
      hit = int'(idx) < NUM_COUNTERS;
      a   = idx[ADDR_W-1:0];
      if (kind == KIND_REPORT && hit) begin
        if (hit_count[a] == '0) first_seen[a] = frame_now;
        last_seen[a] = frame_now;
        if (hit_count[a] != CNT_MAX) hit_count[a] = hit_count[a] + 1'b1;
      end else if (kind == KIND_TICK) begin
        if (frame_now != FRAME_MAX) frame_now = frame_now + 1'b1;
      end
      r.kind          = kind;
      r.idx           = idx;
      r.index_valid   = hit;
      r.event_count   = '0;
      r.first_frame   = NO_FRAME;
      r.last_frame    = NO_FRAME;
      r.current_frame = frame_now;
      if (hit) begin
        r.event_count = hit_count[a];
        if (hit_count[a] != '0) begin
          r.first_frame = {1'b0, first_seen[a]};
          r.last_frame  = {1'b0, last_seen[a]};
        end
      end
      pending_results.push_back(r);
    endfunction

    // Compare one output word with the oldest prediction
    function void check_result(logic [OUT_W-1:0] word);
      bank_result_t exp;
      string        diffs;
      if (pending_results.size() == 0) begin
        report($sformatf("result with no request pending: %h", word));
        return;
      end
      exp   = pending_results.pop_front();
      diffs = "";
      if (word[0] !== exp.index_valid)
        diffs = {diffs, $sformatf(" index_valid %b/%b", word[0], exp.index_valid)};
      if (word[31:1] !== exp.event_count)
        diffs = {diffs, $sformatf(" event_count %0d/%0d", word[31:1], exp.event_count)};
      if (word[63:32] !== exp.first_frame)
        diffs = {diffs, $sformatf(" first_frame %h/%h", word[63:32], exp.first_frame)};
      if (word[95:64] !== exp.last_frame)
        diffs = {diffs, $sformatf(" last_frame %h/%h", word[95:64], exp.last_frame)};
      if (word[126:96] !== exp.current_frame)
        diffs = {diffs, $sformatf(" current_frame %0d/%0d", word[126:96],
                                  exp.current_frame)};
      if (word[127] !== 1'b0)
        diffs = {diffs, " pad bit set"};
      if (diffs != "")
        report($sformatf("kind %0d idx %0d (got/exp):%s", exp.kind, exp.idx, diffs));
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [IDX_W-1:0]   s_tdata;
  logic [KIND_W-1:0]  s_tuser;
  logic               m_tvalid;
  logic               m_tready;
  logic [OUT_W-1:0]   m_tdata;

  counter_bank_scoreboard sb;
  bit                     no_idle;

  event_counter_bank_with_timestamps dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Drive one request from a falling edge and wait for the handshake
  task automatic send_request(input logic [KIND_W-1:0] kind, input logic [IDX_W-1:0] idx);
    int gap;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= idx;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    sb.note_request(kind, idx);
    @(negedge clk);
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Random request: mostly valid indices, some out of range
  task automatic send_random_request();
    int                r;
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  idx;
    r = $urandom_range(0, 99);
    if (r < 50)      kind = KIND_REPORT;
    else if (r < 70) kind = KIND_TICK;
    else if (r < 90) kind = KIND_QUERY;
    else             kind = KIND_SPARE;
    if ($urandom_range(0, 99) < 80) idx = IDX_W'($urandom_range(0, NUM_COUNTERS - 1));
    else                            idx = IDX_W'($urandom_range(NUM_COUNTERS, 255));
    send_request(kind, idx);
  endtask

  // Result side back-pressure
  initial begin
    int hold;
    m_tready = 1'b0;
    hold     = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else if (no_idle || $urandom_range(0, 99) < 65) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // Result checking
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
  end

  // Watchdog
  initial begin
    #6000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    sb       = new();
    no_idle  = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: never fired, repeat reports, ticks, out of range, spare kind
    send_request(KIND_QUERY,  8'd0);
    send_request(KIND_REPORT, 8'd0);
    send_request(KIND_REPORT, 8'd0);
    send_request(KIND_TICK,   8'd0);
    send_request(KIND_REPORT, 8'd0);
    send_request(KIND_REPORT, IDX_W'(NUM_COUNTERS - 1));
    send_request(KIND_QUERY,  IDX_W'(NUM_COUNTERS - 1));
    send_request(KIND_REPORT, IDX_W'(NUM_COUNTERS));
    send_request(KIND_QUERY,  8'd255);
    send_request(KIND_REPORT, 8'd255);
    send_request(KIND_TICK,   8'd200);
    send_request(KIND_SPARE,  8'd0);
    send_request(KIND_SPARE,  8'd100);
    send_request(KIND_TICK,   IDX_W'(NUM_COUNTERS - 1));
    send_request(KIND_REPORT, 8'd1);
    send_request(KIND_QUERY,  8'd1);
    send_request(KIND_QUERY,  IDX_W'(NUM_COUNTERS));
    send_request(KIND_REPORT, 8'd127);
    send_request(KIND_TICK,   8'd0);
    send_request(KIND_REPORT, IDX_W'(NUM_COUNTERS - 1));
    send_request(KIND_QUERY,  8'd0);

    // Random phases; every third phase runs without any idling
    for (int n = 0; n < RAND_ITEMS; n++) begin
      no_idle = ((n / PHASE_LEN) % 3) == 1;
      send_random_request();
    end
    no_idle  = 1'b0;
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/ecbt_pkg.sv
src/ecbt_ram.sv
src/ecbt_ctrl.sv
src/ecbt_dp.sv
src/event_counter_bank_with_timestamps.sv
tb/event_counter_bank_with_timestamps_tb.sv
